// File: design/gng_pkg.sv
// shared types and constants of the gradient noise generator
`default_nettype none

package gng_pkg;

    typedef enum logic [1:0] {
        MODE_LOAD = 2'd0,
        MODE_1D   = 2'd1,
        MODE_2D   = 2'd2,
        MODE_3D   = 2'd3
    } mode_t;

    localparam int COORD_W   = 32;
    localparam int HASH_W    = 8;
    localparam int OUT_W     = 19;
    localparam int OUT_FRAC  = 16;

    // quintic fade coefficients
    localparam int FADE_A    = 6;
    localparam int FADE_B    = 15;
    localparam int FADE_C    = 10;

    // twelve-direction gradient selection
    localparam int GRAD_U_SPLIT = 8;
    localparam int GRAD_V_SPLIT = 4;
    localparam int GRAD_V_XA    = 12;
    localparam int GRAD_V_XB    = 14;

    localparam int FIFO_DEPTH = 4;

endpackage

`default_nettype wire

// File: design/gng_in_if.sv
// input channel of the gradient noise generator
`default_nettype none

interface gng_in_if;
    logic                              valid;
    logic                              ready;
    logic [1:0]                        mode;
    logic [7:0]                        load_index;
    logic [7:0]                        load_value;
    logic signed [gng_pkg::COORD_W-1:0] coord_x;
    logic signed [gng_pkg::COORD_W-1:0] coord_y;
    logic signed [gng_pkg::COORD_W-1:0] coord_z;

    modport source (
        output valid, mode, load_index, load_value, coord_x, coord_y, coord_z,
        input  ready
    );
    modport sink (
        input  valid, mode, load_index, load_value, coord_x, coord_y, coord_z,
        output ready
    );
endinterface

`default_nettype wire

// File: design/gng_out_if.sv
// output channel of the gradient noise generator
`default_nettype none

interface gng_out_if;
    logic                              valid;
    logic                              ready;
    logic signed [gng_pkg::OUT_W-1:0]  noise_value;

    modport source (
        output valid, noise_value,
        input  ready
    );
    modport sink (
        input  valid, noise_value,
        output ready
    );
endinterface

`default_nettype wire

// File: design/gradient_noise_generator.sv
// top level of the gradient noise generator
//
// sample_in carries one item per transfer. mode 0 writes load_value into
// the permutation table at load_index and gives no result; modes 1 to 3
// evaluate 1D, 2D or 3D gradient noise at the signed fixed-point coords
// and give one noise_value on noise_out, in the order the items came in.
// load every table entry before the first evaluation.
// throughput: one item per cycle while noise_out does not stall. from
// the input transfer to noise_out.valid an item passes 4 front stages
// for the three table lookup levels and the fade multiplies, one queue
// slot and 7 back stages for gradients, three lerp levels and saturation.
// the table is replicated once per read pair, and a load writes each
// copy as it passes that copy's stage, so later items see it in order.
// reset empties the pipeline and queue; table contents are undefined.
// when noise_out stalls the back end holds, the queue fills, and then
// sample_in.ready drops until space frees up.
`default_nettype none

module gradient_noise_generator #(
    parameter int TABLE_DEPTH   = 256,
    parameter int FRACTION_BITS = 16
) (
    input  wire logic   clk,
    input  wire logic   rst_n,
    gng_in_if.sink      sample_in,
    gng_out_if.source   noise_out
);

    localparam int EW = 2 + 3 * FRACTION_BITS + 3 * (FRACTION_BITS + 1) + 8 * gng_pkg::HASH_W;

    logic          push_valid, push_ready, pop_valid, pop_ready;
    logic [EW-1:0] push_data, pop_data;

    gng_front #(
        .TABLE_DEPTH   (TABLE_DEPTH),
        .FRACTION_BITS (FRACTION_BITS)
    ) u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .src        (sample_in),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data)
    );

    gng_fifo #(
        .W (EW)
    ) u_fifo (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_data  (push_data),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_data   (pop_data)
    );

    gng_back #(
        .FRACTION_BITS (FRACTION_BITS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_data  (pop_data),
        .dst       (noise_out)
    );

endmodule

`default_nettype wire

// File: design/gng_front.sv
// front end: cell split, fade pipeline and three levels of table hashing
`default_nettype none

module gng_front #(
    parameter int TABLE_DEPTH   = 256,
    parameter int FRACTION_BITS = 16,
    localparam int IW = $clog2(TABLE_DEPTH),
    localparam int FB = FRACTION_BITS,
    localparam int FW = FB + 1,
    localparam int EW = 2 + 3 * FB + 3 * FW + 8 * gng_pkg::HASH_W
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    gng_in_if.sink             src,
    output logic               push_valid,
    input  wire logic          push_ready,
    output logic [EW-1:0]      push_data
);

    localparam int HW = gng_pkg::HASH_W;
    localparam int QW = 2 * FB + 7;
    localparam int PW = FB + 5;
    localparam logic [FB+5:0] FADE_B_ONE = (FB + 6)'(gng_pkg::FADE_B) << FB;
    localparam logic signed [QW-1:0] FADE_C_ONE = (QW)'(gng_pkg::FADE_C) << FB;

    // permutation table copies, one per hashing level and read pair
    logic [HW-1:0] m1 [TABLE_DEPTH];
    logic [HW-1:0] m2 [2][TABLE_DEPTH];
    logic [HW-1:0] m3 [4][TABLE_DEPTH];

    logic adv;

    logic v1_reg, v2_reg, v3_reg, v4_reg;
    gng_pkg::mode_t mode1_reg, mode2_reg, mode3_reg, mode4_reg;
    logic [IW-1:0] lidx1_reg, lidx2_reg, lidx3_reg;
    logic [HW-1:0] lval1_reg, lval2_reg, lval3_reg;
    logic [IW-1:0] cell1_reg [3];
    logic [IW-1:0] cy2_reg, cz2_reg, cz3_reg;
    logic [FB-1:0] fr1_reg [3];
    logic [FB-1:0] fr2_reg [3];
    logic [FB-1:0] fr3_reg [3];
    logic [FB-1:0] fr4_reg [3];

    logic [2*FB-1:0]       t2_2_reg [3];
    logic signed [QW-1:0]  q2_reg [3];
    logic [2*FB-1:0]       t3_3_reg [3];
    logic [PW-1:0]         p3_reg [3];
    logic [2*FB+4:0]       fp4_reg [3];

    logic [HW-1:0] h2_reg [2];
    logic [HW-1:0] h1d3_reg [2];
    logic [HW-1:0] h1d4_reg [2];
    logic [HW-1:0] h3_reg [4];
    logic [HW-1:0] h2d4_reg [4];
    logic [HW-1:0] h4_reg [8];

    logic signed [gng_pkg::COORD_W-1:0] coord [3];
    logic [gng_pkg::COORD_W-1:0]        csh [3];
    logic [IW+7:0]                      lidx_ext;
    logic signed [FB+5:0]               slope [3];
    logic signed [QW-1:0]               q_next [3];
    logic signed [QW-1:0]               p_full [3];
    logic [IW-1:0]                      a2, b2;
    logic [IW-1:0]                      addr3 [4];
    logic [FB:0]                        fade [3];
    logic [HW-1:0]                      cv [8];

    function automatic logic [IW-1:0] hadd(input logic [HW-1:0] h, input logic [IW-1:0] c);
        logic [IW+HW-1:0] s;
        s = (IW + HW)'(h) + (IW + HW)'(c);
        return s[IW-1:0];
    endfunction

    assign push_valid = v4_reg && (mode4_reg != gng_pkg::MODE_LOAD);
    assign adv        = !push_valid || push_ready;
    assign src.ready  = adv;

    always_comb
    begin
        coord[0] = src.coord_x;
        coord[1] = src.coord_y;
        coord[2] = src.coord_z;
        for (int l = 0; l < 3; l++)
        begin
            csh[l] = coord[l] >>> FB;
        end
        lidx_ext = (IW + 8)'(src.load_index);
    end

    always_comb
    begin
        for (int l = 0; l < 3; l++)
        begin
            slope[l]  = $signed((FB + 6)'(gng_pkg::FADE_A) * (FB + 6)'(fr1_reg[l]) - FADE_B_ONE);
            q_next[l] = $signed({1'b0, fr1_reg[l]}) * slope[l];
            p_full[l] = (q2_reg[l] >>> FB) + FADE_C_ONE;
            fade[l]   = fp4_reg[l][2*FB:FB];
        end
        a2 = hadd(h2_reg[0], cy2_reg);
        b2 = hadd(h2_reg[1], cy2_reg);
        for (int j = 0; j < 4; j++)
        begin
            addr3[j] = hadd(h3_reg[j], cz3_reg);
        end
    end

    // hashes reordered by corner: bit 0 x, bit 1 y, bit 2 z
    always_comb
    begin
        for (int c = 0; c < 8; c++)
        begin
            cv[c] = '0;
        end
        case (mode4_reg)
            gng_pkg::MODE_1D:
            begin
                cv[0] = h1d4_reg[0];
                cv[1] = h1d4_reg[1];
            end
            gng_pkg::MODE_2D:
            begin
                cv[0] = h2d4_reg[0];
                cv[1] = h2d4_reg[2];
                cv[2] = h2d4_reg[1];
                cv[3] = h2d4_reg[3];
            end
            gng_pkg::MODE_3D:
            begin
                cv[0] = h4_reg[0];
                cv[1] = h4_reg[4];
                cv[2] = h4_reg[2];
                cv[3] = h4_reg[6];
                cv[4] = h4_reg[1];
                cv[5] = h4_reg[5];
                cv[6] = h4_reg[3];
                cv[7] = h4_reg[7];
            end
            default:
            begin
                cv[0] = '0;
            end
        endcase
    end

    assign push_data = {mode4_reg, fr4_reg[0], fr4_reg[1], fr4_reg[2],
                        fade[0], fade[1], fade[2],
                        cv[0], cv[1], cv[2], cv[3], cv[4], cv[5], cv[6], cv[7]};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= src.valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode1_reg <= gng_pkg::mode_t'(src.mode);
            mode2_reg <= mode1_reg;
            mode3_reg <= mode2_reg;
            mode4_reg <= mode3_reg;
            lidx1_reg <= lidx_ext[IW-1:0];
            lidx2_reg <= lidx1_reg;
            lidx3_reg <= lidx2_reg;
            lval1_reg <= src.load_value;
            lval2_reg <= lval1_reg;
            lval3_reg <= lval2_reg;
            cy2_reg   <= cell1_reg[1];
            cz2_reg   <= cell1_reg[2];
            cz3_reg   <= cz2_reg;
            for (int l = 0; l < 3; l++)
            begin
                cell1_reg[l] <= csh[l][IW-1:0];
                fr1_reg[l]   <= coord[l][FB-1:0];
                fr2_reg[l]   <= fr1_reg[l];
                fr3_reg[l]   <= fr2_reg[l];
                fr4_reg[l]   <= fr3_reg[l];
                t2_2_reg[l]  <= fr1_reg[l] * fr1_reg[l];
                q2_reg[l]    <= q_next[l];
                t3_3_reg[l]  <= t2_2_reg[l][2*FB-1:FB] * fr2_reg[l];
                p3_reg[l]    <= p_full[l][PW-1:0];
                fp4_reg[l]   <= t3_3_reg[l][2*FB-1:FB] * p3_reg[l];
            end

            // level one: cell x and its neighbour
            h2_reg[0] <= m1[cell1_reg[0]];
            h2_reg[1] <= m1[cell1_reg[0] + 1'b1];
            if (v1_reg && mode1_reg == gng_pkg::MODE_LOAD)
            begin
                m1[lidx1_reg] <= lval1_reg;
            end

            // level two: a, a+1, b, b+1
            h3_reg[0]   <= m2[0][a2];
            h3_reg[1]   <= m2[0][a2 + 1'b1];
            h3_reg[2]   <= m2[1][b2];
            h3_reg[3]   <= m2[1][b2 + 1'b1];
            h1d3_reg[0] <= h2_reg[0];
            h1d3_reg[1] <= h2_reg[1];
            if (v2_reg && mode2_reg == gng_pkg::MODE_LOAD)
            begin
                m2[0][lidx2_reg] <= lval2_reg;
                m2[1][lidx2_reg] <= lval2_reg;
            end

            // level three: the eight cube corners
            for (int j = 0; j < 4; j++)
            begin
                h4_reg[2*j]     <= m3[j][addr3[j]];
                h4_reg[2*j + 1] <= m3[j][addr3[j] + 1'b1];
                h2d4_reg[j]     <= h3_reg[j];
            end
            h1d4_reg[0] <= h1d3_reg[0];
            h1d4_reg[1] <= h1d3_reg[1];
            if (v3_reg && mode3_reg == gng_pkg::MODE_LOAD)
            begin
                for (int j = 0; j < 4; j++)
                begin
                    m3[j][lidx3_reg] <= lval3_reg;
                end
            end
        end
    end

endmodule

`default_nettype wire

// File: design/gng_fifo.sv
// short queue between the front and back ends
`default_nettype none

module gng_fifo #(
    parameter int W = 8
) (
    input  wire logic         clk,
    input  wire logic         rst_n,
    input  wire logic         push_valid,
    output logic              push_ready,
    input  wire logic [W-1:0] push_data,
    output logic              pop_valid,
    input  wire logic         pop_ready,
    output logic [W-1:0]      pop_data
);

    localparam int D  = gng_pkg::FIFO_DEPTH;
    localparam int AW = $clog2(D);

    logic [W-1:0]  mem [D];
    logic [AW-1:0] wr_reg, rd_reg;
    logic [AW:0]   cnt_reg;
    logic          push, pop;

    assign push_ready = (cnt_reg != (AW + 1)'(D));
    assign pop_valid  = (cnt_reg != '0);
    assign pop_data   = mem[rd_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_reg  <= '0;
            rd_reg  <= '0;
            cnt_reg <= '0;
        end
        else
        begin
            if (push)
            begin
                wr_reg <= wr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_reg <= rd_reg + 1'b1;
            end
            if (push && !pop)
            begin
                cnt_reg <= cnt_reg + 1'b1;
            end
            else if (pop && !push)
            begin
                cnt_reg <= cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_reg] <= push_data;
        end
    end

endmodule

`default_nettype wire

// File: design/gng_back.sv
// back end: corner gradients, three lerp levels, rescale and saturation
`default_nettype none

module gng_back #(
    parameter int FRACTION_BITS = 16,
    localparam int FB = FRACTION_BITS,
    localparam int FW = FB + 1,
    localparam int EW = 2 + 3 * FB + 3 * FW + 8 * gng_pkg::HASH_W
) (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          pop_valid,
    output logic               pop_ready,
    input  wire logic [EW-1:0] pop_data,
    gng_out_if.source          dst
);

    localparam int HW = gng_pkg::HASH_W;
    localparam int GW = FB + 3;
    localparam int PW = 2 * FB + 6;
    localparam int RW = FB + 12;
    localparam int SHR = (FB >= gng_pkg::OUT_FRAC) ? FB - gng_pkg::OUT_FRAC : 0;
    localparam int SHL = (FB >= gng_pkg::OUT_FRAC) ? 0 : gng_pkg::OUT_FRAC - FB;
    localparam logic signed [GW-1:0] ONE = GW'(1) << FB;
    localparam logic signed [RW-1:0] LIM_HI = (RW'(1) << (gng_pkg::OUT_W - 1)) - 1'b1;
    localparam logic signed [RW-1:0] LIM_LO = ~LIM_HI;

    logic [1:0]    mode_in;
    logic [FB-1:0] fr_in [3];
    logic [FB:0]   fd_in [3];
    logic [HW-1:0] hv [8];

    assign {mode_in, fr_in[0], fr_in[1], fr_in[2], fd_in[0], fd_in[1], fd_in[2],
            hv[0], hv[1], hv[2], hv[3], hv[4], hv[5], hv[6], hv[7]} = pop_data;

    logic [6:0] vld_reg;
    logic       adv;

    gng_pkg::mode_t mode_reg [6];
    logic [FB:0]    u1_reg;
    logic [FB:0]    v1_reg, v2_reg, v3_reg;
    logic [FB:0]    w1_reg, w2_reg, w3_reg, w4_reg, w5_reg;

    logic signed [GW-1:0] g1_reg [8];
    logic signed [GW-1:0] lo2_reg [4];
    logic signed [PW-1:0] px2_reg [4];
    logic signed [GW-1:0] x3_reg [4];
    logic signed [GW-1:0] lo4_reg [2];
    logic signed [PW-1:0] py4_reg [2];
    logic signed [GW-1:0] x0_4_reg, x0_5_reg, x0_6_reg;
    logic signed [GW-1:0] y5_reg [2];
    logic signed [GW-1:0] lo6_reg;
    logic signed [PW-1:0] pz6_reg;
    logic signed [gng_pkg::OUT_W-1:0] noise_reg;

    logic signed [GW-1:0] dx [8], dy [8], dz [8], gu [8], gv [8], g_next [8];
    logic [3:0]           k [8];
    logic signed [PW-1:0] sh_x [4], sh_y [2], sh_z;
    logic signed [GW-1:0] z_val, r_sel;
    logic signed [RW-1:0] r_ext, r_sc, r_sat;

    assign adv       = !vld_reg[6] || dst.ready;
    assign pop_ready = adv;
    assign dst.valid = vld_reg[6];
    assign dst.noise_value = noise_reg;

    always_comb
    begin
        for (int c = 0; c < 8; c++)
        begin
            dx[c] = $signed(GW'(fr_in[0])) - (c[0] ? ONE : '0);
            dy[c] = $signed(GW'(fr_in[1])) - (c[1] ? ONE : '0);
            dz[c] = $signed(GW'(fr_in[2])) - (c[2] ? ONE : '0);
            k[c]  = hv[c][3:0];
            gu[c] = (k[c] < 4'(gng_pkg::GRAD_U_SPLIT)) ? dx[c] : dy[c];
            if (k[c] < 4'(gng_pkg::GRAD_V_SPLIT))
            begin
                gv[c] = dy[c];
            end
            else if (k[c] == 4'(gng_pkg::GRAD_V_XA) || k[c] == 4'(gng_pkg::GRAD_V_XB))
            begin
                gv[c] = dx[c];
            end
            else
            begin
                gv[c] = dz[c];
            end
            case (gng_pkg::mode_t'(mode_in))
                gng_pkg::MODE_1D:
                    g_next[c] = hv[c][0] ? dx[c] : -dx[c];
                gng_pkg::MODE_2D:
                    g_next[c] = (hv[c][0] ? -dx[c] : dx[c]) + (hv[c][1] ? -dy[c] : dy[c]);
                gng_pkg::MODE_3D:
                    g_next[c] = (k[c][0] ? -gu[c] : gu[c]) + (k[c][1] ? -gv[c] : gv[c]);
                default:
                    g_next[c] = '0;
            endcase
        end
    end

    always_comb
    begin
        for (int j = 0; j < 4; j++)
        begin
            sh_x[j] = px2_reg[j] >>> FB;
        end
        for (int j = 0; j < 2; j++)
        begin
            sh_y[j] = py4_reg[j] >>> FB;
        end
        sh_z  = pz6_reg >>> FB;
        z_val = lo6_reg + $signed(sh_z[GW-1:0]);
        case (mode_reg[5])
            gng_pkg::MODE_1D: r_sel = x0_6_reg;
            gng_pkg::MODE_2D: r_sel = lo6_reg;
            default:          r_sel = z_val;
        endcase
        r_ext = RW'(r_sel);
        r_sc  = (r_ext >>> SHR) <<< SHL;
        if (r_sc > LIM_HI)
        begin
            r_sat = LIM_HI;
        end
        else if (r_sc < LIM_LO)
        begin
            r_sat = LIM_LO;
        end
        else
        begin
            r_sat = r_sc;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (adv)
        begin
            vld_reg <= {vld_reg[5:0], pop_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            mode_reg[0] <= gng_pkg::mode_t'(mode_in);
            for (int s = 1; s < 6; s++)
            begin
                mode_reg[s] <= mode_reg[s-1];
            end
            u1_reg <= fd_in[0];
            v1_reg <= fd_in[1];
            w1_reg <= fd_in[2];
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            w2_reg <= w1_reg;
            w3_reg <= w2_reg;
            w4_reg <= w3_reg;
            w5_reg <= w4_reg;
            for (int c = 0; c < 8; c++)
            begin
                g1_reg[c] <= g_next[c];
            end
            // x lerps
            for (int j = 0; j < 4; j++)
            begin
                lo2_reg[j] <= g1_reg[2*j];
                px2_reg[j] <= $signed({1'b0, u1_reg}) *
                              ((GW + 1)'(g1_reg[2*j + 1]) - (GW + 1)'(g1_reg[2*j]));
                x3_reg[j]  <= lo2_reg[j] + $signed(sh_x[j][GW-1:0]);
            end
            // y lerps
            for (int j = 0; j < 2; j++)
            begin
                lo4_reg[j] <= x3_reg[2*j];
                py4_reg[j] <= $signed({1'b0, v3_reg}) *
                              ((GW + 1)'(x3_reg[2*j + 1]) - (GW + 1)'(x3_reg[2*j]));
                y5_reg[j]  <= lo4_reg[j] + $signed(sh_y[j][GW-1:0]);
            end
            x0_4_reg <= x3_reg[0];
            x0_5_reg <= x0_4_reg;
            x0_6_reg <= x0_5_reg;
            // z lerp
            lo6_reg  <= y5_reg[0];
            pz6_reg  <= $signed({1'b0, w5_reg}) *
                        ((GW + 1)'(y5_reg[1]) - (GW + 1)'(y5_reg[0]));
            noise_reg <= r_sat[gng_pkg::OUT_W-1:0];
        end
    end

endmodule

`default_nettype wire
